FILE: sv/ebud_pkg.sv
// Shared constants and types for the edge basis unit direction block.
`timescale 1ns / 1ps

package ebud_pkg;

    // Fixed widths of the direction registers and the result coefficients
    localparam int DIR_W     = 16;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values (Q1.14 unit vector along x)
    localparam logic [DIR_W-1:0] DIR_X_RST = 16'h4000;
    localparam logic [DIR_W-1:0] DIR_Y_RST = 16'h0000;

    // Normalized magnitudes keep their leading one at bit NORM_W-1
    localparam int NORM_W    = 30;
    localparam int RAD_W     = 2 * NORM_W + 1;
    localparam int ROOT_W    = NORM_W + 1;
    localparam int SQ_STAGES = NORM_W + 1;

    // Queue between the front and the back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIR_X = 2'd0,
        REG_DIR_Y = 2'd1
    } t_reg_idx;

    // Per-item sign and degeneracy flags carried alongside the datapath
    typedef struct packed {
        logic neg0;
        logic neg1;
        logic deg;
    } t_flags;

endpackage

FILE: sv/edge_basis_unit_direction.sv
// Top level: configuration registers, front end, queue and back end.
`timescale 1ns / 1ps

// Expresses the programmed direction (dir_x, dir_y) in the basis of a triangle's
// edges v1-v0 and v2-v1 and returns the two coefficients scaled to unit length in
// Q1.FRAC_BITS, masked to 16 bits; a zero determinant or zero result gives zeros
// with o_degenerate set. The block takes one triangle per clock and keeps that
// rate indefinitely while the output side is not stalled. From accept to result a
// triangle passes the front stages, the queue, the normalize stages, the square and
// sum stages, the square root stages, the divider's numerator and quotient stages
// and the output register. The four-entry queue lets the front keep accepting while
// the back is held by a stalled result.
// Write the direction registers only while no transaction is in flight.
module edge_basis_unit_direction #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ebud_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ebud_pkg::DIR_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_x0,
    input  logic signed [COORD_BITS-1:0]        i_y0,
    input  logic signed [COORD_BITS-1:0]        i_x1,
    input  logic signed [COORD_BITS-1:0]        i_y1,
    input  logic signed [COORD_BITS-1:0]        i_x2,
    input  logic signed [COORD_BITS-1:0]        i_y2,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ebud_pkg::OUT_W-1:0]   o_coef_first,
    output logic signed [ebud_pkg::OUT_W-1:0]   o_coef_second,
    output logic                                o_degenerate
);
    import ebud_pkg::*;

    localparam int MW = COORD_BITS + 17;
    localparam int FW = $bits(t_flags);
    localparam int QD = 2 * MW + FW;

    logic [DIR_W-1:0] r_dir_x, r_dir_y;

    logic             w_fr_en, w_fr_v;
    logic [MW-1:0]    w_fr_m0, w_fr_m1;
    t_flags           w_fr_f;
    logic             w_q_full, w_q_empty, w_q_pop;
    logic [QD-1:0]    w_q_data;
    t_flags           w_q_f;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= DIR_X_RST;
            r_dir_y <= DIR_Y_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DIR_X: r_dir_x <= i_cfg_data;
                REG_DIR_Y: r_dir_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front advances unless its last stage holds a transaction the queue cannot take
    assign w_fr_en = !w_fr_v || !w_q_full;
    assign o_stall = !w_fr_en;

    ebud_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fr_en),
        .i_valid (i_valid),
        .i_x0    (i_x0),
        .i_y0    (i_y0),
        .i_x1    (i_x1),
        .i_y1    (i_y1),
        .i_x2    (i_x2),
        .i_y2    (i_y2),
        .i_dir_x (r_dir_x),
        .i_dir_y (r_dir_y),
        .o_valid (w_fr_v),
        .o_mag0  (w_fr_m0),
        .o_mag1  (w_fr_m1),
        .o_flags (w_fr_f)
    );

    ebud_fifo #(
        .WIDTH (QD)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_v && w_fr_en),
        .i_data  ({w_fr_m0, w_fr_m1, w_fr_f}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    assign w_q_f = w_q_data[FW-1:0];

    ebud_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!w_q_empty),
        .o_pop         (w_q_pop),
        .i_mag0        (w_q_data[QD-1 -: MW]),
        .i_mag1        (w_q_data[FW +: MW]),
        .i_flags       (w_q_f),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_coef_first  (o_coef_first),
        .o_coef_second (o_coef_second),
        .o_degenerate  (o_degenerate)
    );

endmodule

FILE: sv/ebud_front.sv
// Front end: edge vectors, adjugate products, determinant sign and classification.
`timescale 1ns / 1ps

module ebud_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_x0,
    input  logic signed [COORD_BITS-1:0]        i_y0,
    input  logic signed [COORD_BITS-1:0]        i_x1,
    input  logic signed [COORD_BITS-1:0]        i_y1,
    input  logic signed [COORD_BITS-1:0]        i_x2,
    input  logic signed [COORD_BITS-1:0]        i_y2,
    input  logic signed [ebud_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [ebud_pkg::DIR_W-1:0]   i_dir_y,
    output logic                                o_valid,
    output logic [COORD_BITS+16:0]              o_mag0,
    output logic [COORD_BITS+16:0]              o_mag1,
    output ebud_pkg::t_flags                    o_flags
);
    import ebud_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = EW + DIR_W;
    localparam int TW = PW + 1;
    localparam int DW = 2 * EW;
    localparam int MW = PW;

    logic                 r_v1, r_v2, r_v3;
    logic signed [EW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [DIR_W-1:0] r_dx, r_dy;
    logic signed [PW-1:0] r_p0a, r_p0b, r_p1a, r_p1b;
    logic signed [DW-1:0] r_pd1, r_pd2;
    logic [MW-1:0]        r_mag0, r_mag1;
    t_flags               r_flags;

    logic signed [TW-1:0] w_t0, w_t1;
    logic                 w_dneg;
    t_flags               w_flags;

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Form the edge vectors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x <= EW'(i_x1) - EW'(i_x0);
            r_e1y <= EW'(i_y1) - EW'(i_y0);
            r_e2x <= EW'(i_x2) - EW'(i_x1);
            r_e2y <= EW'(i_y2) - EW'(i_y1);
            r_dx  <= i_dir_x;
            r_dy  <= i_dir_y;
        end
    end

    // Multiply the adjugate and determinant terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0a <= r_e2y * r_dx;
            r_p0b <= r_e2x * r_dy;
            r_p1a <= r_e1x * r_dy;
            r_p1b <= r_e1y * r_dx;
            r_pd1 <= r_e1x * r_e2y;
            r_pd2 <= r_e1y * r_e2x;
        end
    end

    // Combine terms, fold in the determinant sign, flag degenerate items
    always_comb begin
        w_t0          = TW'(r_p0a) - TW'(r_p0b);
        w_t1          = TW'(r_p1a) - TW'(r_p1b);
        w_dneg        = r_pd1 < r_pd2;
        w_flags.neg0  = w_t0[TW-1] ^ w_dneg;
        w_flags.neg1  = w_t1[TW-1] ^ w_dneg;
        w_flags.deg   = (r_pd1 == r_pd2) || ((w_t0 == '0) && (w_t1 == '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag0  <= w_t0[TW-1] ? MW'(-w_t0) : MW'(w_t0);
            r_mag1  <= w_t1[TW-1] ? MW'(-w_t1) : MW'(w_t1);
            r_flags <= w_flags;
        end
    end

    assign o_valid = r_v3;
    assign o_mag0  = r_mag0;
    assign o_mag1  = r_mag1;
    assign o_flags = r_flags;

endmodule

FILE: sv/ebud_fifo.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module ebud_fifo #(
    parameter int WIDTH = 69
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import ebud_pkg::*;

    logic [WIDTH-1:0]   r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

    // Store the pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_cnt == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;

endmodule

FILE: sv/ebud_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module ebud_sqrt #(
    parameter int SIDE_W = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ebud_pkg::RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [ebud_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);
    import ebud_pkg::*;

    localparam int RW = RAD_W + 1;

    logic              r_v    [0:SQ_STAGES-1];
    logic [RAD_W-1:0]  r_n    [0:SQ_STAGES-1];
    logic [RW-1:0]     r_res  [0:SQ_STAGES-1];
    logic [SIDE_W-1:0] r_side [0:SQ_STAGES-1];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
        localparam logic [RW:0] BITV = (RW+1)'(1) << (2 * (SQ_STAGES - 1 - s));

        logic              w_v;
        logic [RAD_W-1:0]  w_n, n_n;
        logic [RW-1:0]     w_res, n_res;
        logic [SIDE_W-1:0] w_side;
        logic [RW:0]       w_trial;

        if (s == 0) begin : g_in
            assign w_v    = i_valid;
            assign w_n    = i_rad;
            assign w_res  = '0;
            assign w_side = i_side;
        end else begin : g_chain
            assign w_v    = r_v[s-1];
            assign w_n    = r_n[s-1];
            assign w_res  = r_res[s-1];
            assign w_side = r_side[s-1];
        end

        // Try to take the current bit out of the remainder
        always_comb begin
            w_trial = {1'b0, w_res} + BITV;
            if ({2'b00, w_n} >= w_trial) begin
                n_n   = w_n - w_trial[RAD_W-1:0];
                n_res = (w_res >> 1) + BITV[RW-1:0];
            end else begin
                n_n   = w_n;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s]    <= n_n;
                r_res[s]  <= n_res;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_res[SQ_STAGES-1][ROOT_W-1:0];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

FILE: sv/ebud_div.sv
// Pipelined rounding divider, two lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module ebud_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ebud_pkg::NORM_W-1:0] i_a0,
    input  logic [ebud_pkg::NORM_W-1:0] i_a1,
    input  logic [ebud_pkg::ROOT_W-1:0] i_root,
    input  ebud_pkg::t_flags            i_flags,
    output logic                        o_valid,
    output logic [FRAC_BITS:0]          o_q0,
    output logic [FRAC_BITS:0]          o_q1,
    output ebud_pkg::t_flags            o_flags
);
    import ebud_pkg::*;

    localparam int NUMW = NORM_W + 1 + FRAC_BITS;
    localparam int QW   = FRAC_BITS + 1;

    logic              r_pv;
    logic [NUMW-1:0]   r_pnum [0:1];
    logic [ROOT_W-1:0] r_pr;
    t_flags            r_pf;

    logic              r_v    [0:QW-1];
    logic [ROOT_W-1:0] r_r    [0:QW-1];
    t_flags            r_f    [0:QW-1];
    logic [NUMW-1:0]   r_num  [0:QW-1][0:1];
    logic [ROOT_W-1:0] r_rem  [0:QW-1][0:1];
    logic [QW-1:0]     r_q    [0:QW-1][0:1];

    // Build the rounded numerators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pnum[0] <= NUMW'({i_a0, {FRAC_BITS{1'b0}}}) + NUMW'(i_root >> 1);
            r_pnum[1] <= NUMW'({i_a1, {FRAC_BITS{1'b0}}}) + NUMW'(i_root >> 1);
            r_pr      <= i_root;
            r_pf      <= i_flags;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        localparam int J = FRAC_BITS - s;

        logic              w_v;
        logic [ROOT_W-1:0] w_r;
        t_flags            w_f;

        if (s == 0) begin : g_in
            assign w_v = r_pv;
            assign w_r = r_pr;
            assign w_f = r_pf;
        end else begin : g_chain
            assign w_v = r_v[s-1];
            assign w_r = r_r[s-1];
            assign w_f = r_f[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s] <= w_r;
                r_f[s] <= w_f;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [NUMW-1:0]   w_num;
            logic [ROOT_W-1:0] w_rem, n_rem;
            logic [QW-1:0]     w_q;
            logic [ROOT_W:0]   w_sh;
            logic              w_ge;

            if (s == 0) begin : g_in
                assign w_num = r_pnum[l];
                assign w_rem = ROOT_W'(r_pnum[l][NUMW-1:QW]);
                assign w_q   = '0;
            end else begin : g_chain
                assign w_num = r_num[s-1][l];
                assign w_rem = r_rem[s-1][l];
                assign w_q   = r_q[s-1][l];
            end

            // Shift in the next numerator bit and subtract if it fits
            always_comb begin
                w_sh  = {w_rem, w_num[J]};
                w_ge  = w_sh >= {1'b0, w_r};
                n_rem = w_ge ? ROOT_W'(w_sh - {1'b0, w_r}) : w_sh[ROOT_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[s][l] <= w_num;
                    r_rem[s][l] <= n_rem;
                    r_q[s][l]   <= {w_q[QW-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q0    = r_q[QW-1][0];
    assign o_q1    = r_q[QW-1][1];
    assign o_flags = r_f[QW-1];

endmodule

FILE: sv/ebud_back.sv
// Back end: normalize, square, root, divide and drive the result register.
`timescale 1ns / 1ps

module ebud_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_pop,
    input  logic [COORD_BITS+16:0]          i_mag0,
    input  logic [COORD_BITS+16:0]          i_mag1,
    input  ebud_pkg::t_flags                i_flags,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic signed [ebud_pkg::OUT_W-1:0] o_coef_first,
    output logic signed [ebud_pkg::OUT_W-1:0] o_coef_second,
    output logic                            o_degenerate
);
    import ebud_pkg::*;

    localparam int MW     = COORD_BITS + 17;
    localparam int NW     = (MW > NORM_W) ? MW : NORM_W;
    localparam int NL     = $clog2(NW);
    localparam int FW     = $bits(t_flags);
    localparam int SIDE_W = 2 * NORM_W + FW;
    localparam int QW     = FRAC_BITS + 1;
    localparam int QX     = (QW > OUT_W) ? QW : OUT_W;

    logic w_en;

    logic          r_nv [0:NL-1];
    logic [NW-1:0] r_na0 [0:NL-1];
    logic [NW-1:0] r_na1 [0:NL-1];
    t_flags        r_nf [0:NL-1];

    logic                  r_sv, r_uv;
    logic [NORM_W-1:0]     r_sa0, r_sa1, r_ua0, r_ua1;
    logic [2*NORM_W-1:0]   r_sq0, r_sq1;
    logic [RAD_W-1:0]      r_rad;
    t_flags                r_sf, r_uf;
    logic [NORM_W-1:0]     w_a0t, w_a1t;

    logic                  w_rt_v;
    logic [ROOT_W-1:0]     w_root;
    logic [SIDE_W-1:0]     w_rt_side;
    t_flags                w_rt_f;

    logic                  w_dv_v;
    logic [QW-1:0]         w_q0, w_q1;
    t_flags                w_dv_f;
    logic [QX-1:0]         w_c0, w_c1;

    logic                  r_out_v;
    logic [OUT_W-1:0]      r_c0, r_c1;
    logic                  r_deg;

    // Whole back pipeline moves when the result register can take a transaction
    assign w_en  = !r_out_v || !i_stall;
    assign o_pop = w_en && i_valid;

    // Normalize: shift both magnitudes left until the leading one is at the top
    for (genvar s = 0; s < NL; s++) begin : g_norm
        localparam int K = 1 << (NL - 1 - s);

        logic          w_v;
        logic [NW-1:0] w_a0, w_a1, w_or;
        t_flags        w_f;

        if (s == 0) begin : g_in
            assign w_v  = i_valid;
            assign w_a0 = NW'(i_mag0);
            assign w_a1 = NW'(i_mag1);
            assign w_f  = i_flags;
        end else begin : g_chain
            assign w_v  = r_nv[s-1];
            assign w_a0 = r_na0[s-1];
            assign w_a1 = r_na1[s-1];
            assign w_f  = r_nf[s-1];
        end

        assign w_or = w_a0 | w_a1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[s] <= 1'b0;
            end else if (w_en) begin
                r_nv[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_or[NW-1 -: K] == '0) begin
                    r_na0[s] <= w_a0 << K;
                    r_na1[s] <= w_a1 << K;
                end else begin
                    r_na0[s] <= w_a0;
                    r_na1[s] <= w_a1;
                end
                r_nf[s] <= w_f;
            end
        end
    end

    // Keep the top bits, leading one lands on bit NORM_W-1
    assign w_a0t = r_na0[NL-1][NW-1 -: NORM_W];
    assign w_a1t = r_na1[NL-1][NW-1 -: NORM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_uv <= 1'b0;
        end else if (w_en) begin
            r_sv <= r_nv[NL-1];
            r_uv <= r_sv;
        end
    end

    // Square, then sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq0 <= w_a0t * w_a0t;
            r_sq1 <= w_a1t * w_a1t;
            r_sa0 <= w_a0t;
            r_sa1 <= w_a1t;
            r_sf  <= r_nf[NL-1];
            r_rad <= RAD_W'(r_sq0) + RAD_W'(r_sq1);
            r_ua0 <= r_sa0;
            r_ua1 <= r_sa1;
            r_uf  <= r_sf;
        end
    end

    ebud_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_uv),
        .i_rad   (r_rad),
        .i_side  ({r_ua0, r_ua1, r_uf}),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    assign w_rt_f = w_rt_side[FW-1:0];

    ebud_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rt_v),
        .i_a0    (w_rt_side[SIDE_W-1 -: NORM_W]),
        .i_a1    (w_rt_side[FW +: NORM_W]),
        .i_root  (w_root),
        .i_flags (w_rt_f),
        .o_valid (w_dv_v),
        .o_q0    (w_q0),
        .o_q1    (w_q1),
        .o_flags (w_dv_f)
    );

    // Reapply signs
    assign w_c0 = w_dv_f.neg0 ? -QX'(w_q0) : QX'(w_q0);
    assign w_c1 = w_dv_f.neg1 ? -QX'(w_q1) : QX'(w_q1);

    // Result register, zeros for degenerate triangles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c0  <= w_dv_f.deg ? '0 : w_c0[OUT_W-1:0];
            r_c1  <= w_dv_f.deg ? '0 : w_c1[OUT_W-1:0];
            r_deg <= w_dv_f.deg;
        end
    end

    assign o_valid       = r_out_v;
    assign o_coef_first  = r_c0;
    assign o_coef_second = r_c1;
    assign o_degenerate  = r_deg;

endmodule

FILE: sv/ebud_chk.sv
// Port-level checker for the edge basis unit direction block, with its bind.
`timescale 1ns / 1ps

module ebud_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [15:0] i_coef_first,
    input logic [15:0] i_coef_second,
    input logic        i_degenerate
);

    // Degenerate results carry zero coefficients
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> (i_coef_first == '0) && (i_coef_second == '0))
        else $error("degenerate result with nonzero coefficient");

    // Reset empties the result register
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_coef_first)
            && $stable(i_coef_second) && $stable(i_degenerate))
        else $error("stalled result changed");

endmodule

bind edge_basis_unit_direction ebud_chk u_ebud_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_valid),
    .i_out_stall   (i_stall),
    .i_coef_first  (o_coef_first),
    .i_coef_second (o_coef_second),
    .i_degenerate  (o_degenerate)
);
